// ----- src/vpfa_pkg.sv -----
// shared types and constants of the video packet frame assembler
package vpfa_pkg;

  // packet classification taken from the header id
  typedef enum logic [1:0] {
    KIND_NORMAL   = 2'd0,
    KIND_DISCARD  = 2'd1,
    KIND_MISMATCH = 2'd2
  } packet_kind_e;

  // configuration register indexes
  localparam logic [1:0] REG_PAYLOAD_BYTES       = 2'd0;
  localparam logic [1:0] REG_PACKETS_PER_SEGMENT = 2'd1;
  localparam logic [1:0] REG_SEGMENTS_PER_FRAME  = 2'd2;

  // header layout
  localparam int          HEADER_BYTES         = 4;
  localparam logic [3:0]  DISCARD_NIBBLE       = 4'hf;
  localparam logic [11:0] PACKET_NUM_MASK      = 12'hfff;
  localparam logic [2:0]  SEGMENT_NUM_MASK     = 3'h7;
  localparam logic [11:0] SEGMENT_CHECK_PACKET = 12'd20;

  // register reset values
  localparam logic [7:0] PAYLOAD_BYTES_RST       = 8'd160;
  localparam logic [5:0] PACKETS_PER_SEGMENT_RST = 6'd60;
  localparam logic [2:0] SEGMENTS_PER_FRAME_RST  = 3'd4;

endpackage

// ----- src/video_packet_frame_assembler_core.sv -----
// video packet frame assembler: packet parsing, frame tracking and buffer addressing
// a word that yields a result is registered in stages a, b and c before the master side
// throughput: one input word per cycle while the master side accepts (back-pressure stalls
// the input); the address product runs in a two-stage multiply pipeline behind the parser
// reset: asynchronous active low; clears parser state, pipeline valids and loads the
// register defaults (160 payload bytes, 60 packets, 4 segments); no frame active after reset
module video_packet_frame_assembler_core
  import vpfa_pkg::*;
#(
  parameter int MAX_PAYLOAD_BYTES = 240,
  parameter int MAX_PACKETS       = 60,
  parameter int MAX_SEGMENTS      = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
  input  logic [0:0]  s_axis_tuser,   // [0] frame_start
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [15:0] write_address, [23:16] write_data
  output logic        m_axis_tlast,   // frame_end
  output logic [2:0]  m_axis_tuser    // [0] write_valid, [1] frame_ok, [2] resync_request
);

  localparam int PL_W  = $clog2(MAX_PAYLOAD_BYTES + 1);
  localparam int PPS_W = $clog2(MAX_PACKETS + 1);
  localparam int PKT_W = $clog2(MAX_PACKETS);
  localparam int BP_W  = $clog2(MAX_PAYLOAD_BYTES + HEADER_BYTES);
  localparam int IDX_W = $clog2(MAX_SEGMENTS * MAX_PACKETS);
  localparam int AW    = (IDX_W + PL_W + 1 > 16) ? IDX_W + PL_W + 1 : 16;

  // configuration registers
  logic [7:0] payload_bytes_q;
  logic [5:0] packets_per_segment_q;
  logic [2:0] segments_per_frame_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      payload_bytes_q       <= PAYLOAD_BYTES_RST;
      packets_per_segment_q <= PACKETS_PER_SEGMENT_RST;
      segments_per_frame_q  <= SEGMENTS_PER_FRAME_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_PAYLOAD_BYTES:       payload_bytes_q       <= cfg_data_i;
        REG_PACKETS_PER_SEGMENT: packets_per_segment_q <= cfg_data_i[5:0];
        REG_SEGMENTS_PER_FRAME:  segments_per_frame_q  <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // saturated register values
  logic [PL_W-1:0]  pl;
  logic [PPS_W-1:0] pps;
  logic [2:0]       spf;

  always_comb begin
    if (payload_bytes_q == 8'd0) begin
      pl = PL_W'(1);
    end else if ({1'b0, payload_bytes_q} > 9'(MAX_PAYLOAD_BYTES)) begin
      pl = PL_W'(MAX_PAYLOAD_BYTES);
    end else begin
      pl = PL_W'(payload_bytes_q);
    end
    if (packets_per_segment_q == 6'd0) begin
      pps = PPS_W'(1);
    end else if ({1'b0, packets_per_segment_q} > 7'(MAX_PACKETS)) begin
      pps = PPS_W'(MAX_PACKETS);
    end else begin
      pps = PPS_W'(packets_per_segment_q);
    end
    if (segments_per_frame_q == 3'd0) begin
      spf = 3'd1;
    end else if (segments_per_frame_q > 3'(MAX_SEGMENTS)) begin
      spf = 3'(MAX_SEGMENTS);
    end else begin
      spf = segments_per_frame_q;
    end
  end

  // parser state
  logic [BP_W-1:0]  byte_position_q, byte_position_d;
  logic [PKT_W-1:0] packet_count_q, packet_count_d;
  logic [2:0]       segment_count_q, segment_count_d;
  logic [7:0]       header_id_high_q, header_id_high_d;
  packet_kind_e     packet_kind_q, packet_kind_d;
  logic             discard_segment_flag_q, discard_segment_flag_d;
  logic             frame_active_q, frame_active_d;

  // pipeline handshake
  logic a_en, b_en, c_en;
  logic in_accept;

  // result of the parser for the current word
  logic             res_wv, res_fend, res_fok, res_rs;
  logic [2:0]       res_seg_m1;
  logic [PKT_W-1:0] res_pkt;
  logic [BP_W-1:0]  off;
  logic             last;
  logic [11:0]      hdr_num;
  logic [2:0]       hdr_seg;
  logic [PKT_W:0]   pkt_inc;

  assign in_accept = s_axis_tvalid & s_axis_tready;
  assign hdr_num   = {header_id_high_q[3:0], s_axis_tdata} & PACKET_NUM_MASK;
  assign hdr_seg   = header_id_high_q[6:4] & SEGMENT_NUM_MASK;

  // packet parser and frame tracking
  always_comb begin
    byte_position_d        = byte_position_q;
    packet_count_d         = packet_count_q;
    segment_count_d        = segment_count_q;
    header_id_high_d       = header_id_high_q;
    packet_kind_d          = packet_kind_q;
    discard_segment_flag_d = discard_segment_flag_q;
    frame_active_d         = frame_active_q;
    res_wv     = 1'b0;
    res_fend   = 1'b0;
    res_fok    = 1'b0;
    res_rs     = 1'b0;
    res_seg_m1 = segment_count_q - 3'd1;
    res_pkt    = packet_count_q;
    off        = byte_position_q - BP_W'(HEADER_BYTES);
    last       = ({1'b0, off} + 1'b1) >= (BP_W + 1)'(pl);
    pkt_inc    = {1'b0, packet_count_q} + 1'b1;
    if (in_accept) begin
      if (s_axis_tuser[0]) begin
        byte_position_d        = '0;
        packet_count_d         = '0;
        segment_count_d        = 3'd1;
        discard_segment_flag_d = 1'b0;
        packet_kind_d          = KIND_NORMAL;
        frame_active_d         = 1'b1;
        res_seg_m1             = 3'd0;
        res_pkt                = '0;
      end
      if (frame_active_d) begin
        if (byte_position_d == BP_W'(0)) begin
          header_id_high_d = s_axis_tdata;
          byte_position_d  = BP_W'(1);
        end else if (byte_position_d == BP_W'(1)) begin
          // classify the packet from the 16-bit id
          packet_kind_d = KIND_NORMAL;
          if ((header_id_high_q[3:0] & DISCARD_NIBBLE) == DISCARD_NIBBLE) begin
            packet_kind_d = KIND_DISCARD;
          end else if (hdr_num != 12'(packet_count_q)) begin
            packet_kind_d = KIND_MISMATCH;
          end else if (hdr_num == SEGMENT_CHECK_PACKET) begin
            if (hdr_seg == 3'd0) begin
              discard_segment_flag_d = 1'b1;
            end else if (hdr_seg != segment_count_q) begin
              packet_kind_d = KIND_MISMATCH;
            end
          end
          byte_position_d = BP_W'(2);
        end else if (byte_position_d < BP_W'(HEADER_BYTES)) begin
          byte_position_d = byte_position_d + 1'b1;
        end else begin
          // payload word
          res_wv = (packet_kind_q != KIND_DISCARD);
          if (!last) begin
            byte_position_d = byte_position_d + 1'b1;
          end else begin
            byte_position_d = '0;
            unique case (packet_kind_q)
              KIND_DISCARD: begin
                if (packet_count_q == '0 && segment_count_q == 3'd1) begin
                  res_fend       = 1'b1;
                  frame_active_d = 1'b0;
                end
              end
              KIND_MISMATCH: begin
                res_fend       = 1'b1;
                res_rs         = 1'b1;
                frame_active_d = 1'b0;
              end
              default: begin
                packet_count_d = PKT_W'(pkt_inc);
                if (pkt_inc >= (PKT_W + 1)'(pps)) begin
                  packet_count_d = '0;
                  if (discard_segment_flag_q) begin
                    discard_segment_flag_d = 1'b0;
                  end else if (segment_count_q >= spf) begin
                    res_fend       = 1'b1;
                    res_fok        = 1'b1;
                    frame_active_d = 1'b0;
                  end else begin
                    segment_count_d = segment_count_q + 3'd1;
                  end
                end
              end
            endcase
            packet_kind_d = KIND_NORMAL;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_position_q        <= '0;
      packet_count_q         <= '0;
      segment_count_q        <= 3'd1;
      header_id_high_q       <= '0;
      packet_kind_q          <= KIND_NORMAL;
      discard_segment_flag_q <= 1'b0;
      frame_active_q         <= 1'b0;
    end else begin
      byte_position_q        <= byte_position_d;
      packet_count_q         <= packet_count_d;
      segment_count_q        <= segment_count_d;
      header_id_high_q       <= header_id_high_d;
      packet_kind_q          <= packet_kind_d;
      discard_segment_flag_q <= discard_segment_flag_d;
      frame_active_q         <= frame_active_d;
    end
  end

  // pipeline registers: stage a holds the parser result, b the packet index, c the output
  logic             a_valid_q, b_valid_q, c_valid_q;
  logic             a_wv_q, a_fend_q, a_fok_q, a_rs_q;
  logic [7:0]       a_data_q;
  logic [2:0]       a_seg_m1_q;
  logic [PPS_W-1:0] a_pps_q;
  logic [PKT_W-1:0] a_pkt_q;
  logic [PL_W-1:0]  a_pl_q, a_off_q;
  logic             b_wv_q, b_fend_q, b_fok_q, b_rs_q;
  logic [7:0]       b_data_q;
  logic [IDX_W-1:0] b_idx_q;
  logic [PL_W-1:0]  b_pl_q, b_off_q;
  logic             c_wv_q, c_fend_q, c_fok_q, c_rs_q;
  logic [7:0]       c_data_q;
  logic [15:0]      c_addr_q;
  logic [AW-1:0]    addr_full;

  assign c_en          = !c_valid_q || m_axis_tready;
  assign b_en          = !b_valid_q || c_en;
  assign a_en          = !a_valid_q || b_en;
  assign s_axis_tready = a_en;
  assign addr_full     = AW'(b_idx_q) * AW'(b_pl_q) + AW'(b_off_q);

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (a_en) a_valid_q <= in_accept & (res_wv | res_fend);
      if (b_en) b_valid_q <= a_valid_q;
      if (c_en) c_valid_q <= b_valid_q;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (a_en) begin
      a_wv_q     <= res_wv;
      a_fend_q   <= res_fend;
      a_fok_q    <= res_fok;
      a_rs_q     <= res_rs;
      a_data_q   <= res_wv ? s_axis_tdata : 8'd0;
      a_seg_m1_q <= res_seg_m1;
      a_pps_q    <= pps;
      a_pkt_q    <= res_pkt;
      a_pl_q     <= pl;
      a_off_q    <= PL_W'(off);
    end
    if (b_en) begin
      b_wv_q   <= a_wv_q;
      b_fend_q <= a_fend_q;
      b_fok_q  <= a_fok_q;
      b_rs_q   <= a_rs_q;
      b_data_q <= a_data_q;
      b_idx_q  <= IDX_W'(IDX_W'(a_seg_m1_q) * IDX_W'(a_pps_q) + IDX_W'(a_pkt_q));
      b_pl_q   <= a_pl_q;
      b_off_q  <= a_off_q;
    end
    if (c_en) begin
      c_wv_q   <= b_wv_q;
      c_fend_q <= b_fend_q;
      c_fok_q  <= b_fok_q;
      c_rs_q   <= b_rs_q;
      c_data_q <= b_data_q;
      c_addr_q <= b_wv_q ? addr_full[15:0] : 16'd0;
    end
  end

  // output stream
  assign m_axis_tvalid = c_valid_q;
  assign m_axis_tdata  = {c_data_q, c_addr_q};
  assign m_axis_tlast  = c_fend_q;
  assign m_axis_tuser  = {c_rs_q, c_fok_q, c_wv_q};

endmodule

// ----- verif/vpfa_write_checker.sv -----
// checker for the frame assembler: predicts buffer writes and frame status, compares the output
module vpfa_write_checker
  import vpfa_pkg::*;
#(
  parameter int MAX_PAYLOAD_BYTES = 240,
  parameter int MAX_PACKETS       = 60,
  parameter int MAX_SEGMENTS      = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
  input  logic [0:0]  s_axis_tuser,   // [0] frame_start
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,   // [15:0] write_address, [23:16] write_data
  input  logic        m_axis_tlast,   // frame_end
  input  logic [2:0]  m_axis_tuser,   // [0] write_valid, [1] frame_ok, [2] resync_request
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct {
    logic        write_valid;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic        frame_end;
    logic        frame_ok;
    logic        resync_request;
  } buffer_write_t;

  // register copies as written
  logic [7:0] payload_reg;
  logic [5:0] packets_reg;
  logic [2:0] segments_reg;

  // assembler state
  logic [7:0]   byte_pos;
  logic [5:0]   packet_cnt;
  logic [2:0]   segment_cnt;
  logic [7:0]   id_high;
  packet_kind_e kind;
  logic         segment_redo;
  logic         frame_on;

  buffer_write_t buffer_writes_q[$];
  buffer_write_t expected_w;

  function automatic int fit(input int v, input int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int field_bad(input string name, input int expv, input int actv);
    if (expv != actv) begin
      $error("%s: expected %0d, actual %0d", name, expv, actv);
      return 1;
    end
    return 0;
  endfunction

  // advance the assembler by one received byte, queue the buffer write it causes
  task automatic assemble_byte(input logic [7:0] b, input logic fs);
    int            pl;
    int            pps;
    int            spf;
    int            off;
    int            num;
    int            seg;
    int            addr;
    logic [15:0]   id;
    logic          last;
    buffer_write_t w;
    pl  = fit(payload_reg, MAX_PAYLOAD_BYTES);
    pps = fit(packets_reg, MAX_PACKETS);
    spf = fit(segments_reg, MAX_SEGMENTS);
    w = '{default: 0};
    if (fs) begin
      byte_pos     = '0;
      packet_cnt   = '0;
      segment_cnt  = 3'd1;
      segment_redo = 1'b0;
      kind         = KIND_NORMAL;
      frame_on     = 1'b1;
    end
    if (!frame_on) return;

    // header: id bytes classify the packet, checksum bytes are skipped
    if (byte_pos == 0) begin
      id_high  = b;
      byte_pos = 8'd1;
      return;
    end
    if (byte_pos == 1) begin
      id  = {id_high, b};
      num = int'(id[11:0]);
      seg = int'(id[14:12]);
      kind = KIND_NORMAL;
      if (id_high[3:0] == DISCARD_NIBBLE) begin
        kind = KIND_DISCARD;
      end else if (num != int'(packet_cnt)) begin
        kind = KIND_MISMATCH;
      end else if (num == int'(SEGMENT_CHECK_PACKET)) begin
        if (seg == 0) segment_redo = 1'b1;
        else if (seg != int'(segment_cnt)) kind = KIND_MISMATCH;
      end
      byte_pos = 8'd2;
      return;
    end
    if (byte_pos < HEADER_BYTES) begin
      byte_pos++;
      return;
    end

    // payload
    off  = int'(byte_pos) - HEADER_BYTES;
    last = (off + 1 >= pl);
    if (kind != KIND_DISCARD) begin
      addr = ((int'(segment_cnt) - 1) * pps + int'(packet_cnt)) * pl + off;
      w.write_valid   = 1'b1;
      w.write_data    = b;
      w.write_address = addr[15:0];
    end
    if (!last) begin
      byte_pos++;
    end else begin
      byte_pos = '0;
      case (kind)
        KIND_DISCARD: begin
          // a discard packet at the very start aborts the frame
          if (packet_cnt == 0 && segment_cnt == 1) begin
            w.frame_end = 1'b1;
            frame_on    = 1'b0;
          end
        end
        KIND_MISMATCH: begin
          w.frame_end      = 1'b1;
          w.resync_request = 1'b1;
          frame_on         = 1'b0;
        end
        default: begin
          packet_cnt++;
          if (int'(packet_cnt) >= pps) begin
            packet_cnt = '0;
            if (segment_redo) begin
              segment_redo = 1'b0;
            end else if (int'(segment_cnt) >= spf) begin
              w.frame_end = 1'b1;
              w.frame_ok  = 1'b1;
              frame_on    = 1'b0;
            end else begin
              segment_cnt++;
            end
          end
        end
      endcase
      kind = KIND_NORMAL;
    end
    if (w.write_valid || w.frame_end) buffer_writes_q.push_back(w);
  endtask

  // watch register writes, input and output words
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      payload_reg  = PAYLOAD_BYTES_RST;
      packets_reg  = PACKETS_PER_SEGMENT_RST;
      segments_reg = SEGMENTS_PER_FRAME_RST;
      byte_pos     = '0;
      packet_cnt   = '0;
      segment_cnt  = 3'd1;
      id_high      = '0;
      kind         = KIND_NORMAL;
      segment_redo = 1'b0;
      frame_on     = 1'b0;
      buffer_writes_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_PAYLOAD_BYTES:       payload_reg  = cfg_data_i;
          REG_PACKETS_PER_SEGMENT: packets_reg  = cfg_data_i[5:0];
          REG_SEGMENTS_PER_FRAME:  segments_reg = cfg_data_i[2:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) assemble_byte(s_axis_tdata, s_axis_tuser[0]);
      if (m_axis_tvalid && m_axis_tready) begin
        if (buffer_writes_q.size() == 0) begin
          $error("output word with no write pending: tdata %h tlast %b tuser %b",
                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
          fail_count_o++;
        end else begin
          expected_w = buffer_writes_q.pop_front();
          fail_count_o += field_bad("write_valid", expected_w.write_valid, m_axis_tuser[0]);
          fail_count_o += field_bad("write_address", expected_w.write_address,
                                    m_axis_tdata[15:0]);
          fail_count_o += field_bad("write_data", expected_w.write_data, m_axis_tdata[23:16]);
          fail_count_o += field_bad("frame_end", expected_w.frame_end, m_axis_tlast);
          fail_count_o += field_bad("frame_ok", expected_w.frame_ok, m_axis_tuser[1]);
          fail_count_o += field_bad("resync_request", expected_w.resync_request,
                                    m_axis_tuser[2]);
        end
      end
      pending_o = buffer_writes_q.size();
    end
  end

endmodule

// ----- verif/tb.sv -----
// testbench top for the frame assembler: byte stream stimulus, receiver stalls and verdict
module tb
  import vpfa_pkg::*;
;

  localparam int MAX_PAYLOAD_BYTES = 240;
  localparam int MAX_PACKETS       = 60;
  localparam int MAX_SEGMENTS      = 4;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam int MODE_RANDOM   = 0;
  localparam int MODE_SEG_ZERO = 1;
  localparam int MODE_SEG_BAD  = 2;

  localparam int PHASES      = 9;
  localparam int HOLD_PHASE  = 4;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 8;
  localparam int CYCLE_LIMIT = 250000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [7:0]  cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] stream_byte
  logic [0:0]  s_axis_tuser;   // [0] frame_start
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [15:0] write_address, [23:16] write_data
  logic        m_axis_tlast;   // frame_end
  logic [2:0]  m_axis_tuser;   // [0] write_valid, [1] frame_ok, [2] resync_request

  int fail_count;
  int pending;
  int bytes_left;
  int holds_asked;
  int holds_served;
  int cycles;
  bit quiet;

  // per phase register values (raw, out-of-range ones saturate), byte budget, first frame kind
  int ph_pl[PHASES]     = '{1, 1, 0, 255, 3, 2, 240, 1, 4};
  int ph_pps[PHASES]    = '{21, 21, 1, 0, 3, 63, 60, 22, 2};
  int ph_spf[PHASES]    = '{1, 1, 1, 0, 3, 7, 4, 2, 4};
  int ph_budget[PHASES] = '{200, 150, 100, 200, 200, 150, 150, 150, 150};
  int ph_mode[PHASES]   = '{MODE_SEG_ZERO, MODE_SEG_BAD, MODE_RANDOM, MODE_RANDOM,
                            MODE_RANDOM, MODE_RANDOM, MODE_RANDOM, MODE_RANDOM, MODE_RANDOM};

  video_packet_frame_assembler_core #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES),
    .MAX_PACKETS      (MAX_PACKETS),
    .MAX_SEGMENTS     (MAX_SEGMENTS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  vpfa_write_checker #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES),
    .MAX_PACKETS      (MAX_PACKETS),
    .MAX_SEGMENTS     (MAX_SEGMENTS)
  ) u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic int fit(input int v, input int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // offer one byte, with an occasional idle burst ahead of it
  task automatic send_byte(input logic [7:0] b, input logic fs);
    if (!quiet && $urandom_range(0, 15) == 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom_range(0, 255));
      s_axis_tuser  <= 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= fs;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // stop offering and wait until every pending write has come out
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  // write all registers, upper bits of the narrow ones carry junk
  task automatic configure(input int pl, input int pps, input int spf);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_PAYLOAD_BYTES;
    cfg_data_i  <= pl[7:0];
    @(negedge clk_i);
    cfg_index_i <= REG_PACKETS_PER_SEGMENT;
    cfg_data_i  <= {2'($urandom_range(0, 3)), pps[5:0]};
    @(negedge clk_i);
    cfg_index_i <= REG_SEGMENTS_PER_FRAME;
    cfg_data_i  <= {5'($urandom_range(0, 31)), spf[2:0]};
    @(negedge clk_i);
    cfg_index_i <= REG_UNUSED;
    cfg_data_i  <= 8'($urandom_range(0, 255));
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // one frame attempt: mostly well-formed packets, with discards, bad numbers and cut packets
  task automatic send_frame(input int pl, input int pps, input int spf, input int mode);
    int          pkt;
    int          seg;
    int          r;
    int          cut;
    int          num;
    int          segn;
    int          n;
    logic        redo;
    logic        done;
    logic        first;
    logic        discard;
    logic [15:0] id;
    logic [7:0]  b;
    pkt   = 0;
    seg   = 1;
    redo  = 1'b0;
    done  = 1'b0;
    first = 1'b1;
    while (!done && bytes_left > 0) begin
      r       = (mode == MODE_RANDOM) ? $urandom_range(0, 99) : 99;
      cut     = pl + HEADER_BYTES;
      num     = pkt;
      segn    = seg;
      discard = 1'b0;
      if (r < 5) discard = 1'b1;
      else if (r < 8) num = pkt ^ (1 << $urandom_range(0, 11));
      else if (r < 10) cut = $urandom_range(1, pl + HEADER_BYTES - 1);
      // segment number check at packet 20
      if (num == int'(SEGMENT_CHECK_PACKET) && !discard) begin
        if (mode == MODE_SEG_ZERO) begin
          segn = 0;
          mode = MODE_RANDOM;
        end else if (mode == MODE_SEG_BAD) begin
          segn = seg + 1;
          mode = MODE_RANDOM;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 12) segn = 0;
          else if (r < 18) segn = seg + 1;
        end
      end
      id[15]    = 1'($urandom_range(0, 1));
      id[14:12] = segn[2:0];
      id[11:0]  = num[11:0];
      if (discard) id[11:8] = DISCARD_NIBBLE;
      for (n = 0; n < cut; n++) begin
        if (n == 0) b = id[15:8];
        else if (n == 1) b = id[7:0];
        else b = 8'($urandom_range(0, 255));
        send_byte(b, first && n == 0);
      end
      bytes_left -= cut;
      first = 1'b0;
      // follow the frame the way a correct receiver would
      if (cut < pl + HEADER_BYTES) begin
        done = 1'b1;
      end else if (discard) begin
        if (pkt == 0 && seg == 1) done = 1'b1;
      end else if (num != pkt) begin
        done = 1'b1;
      end else if (pkt == int'(SEGMENT_CHECK_PACKET) && segn != 0 && segn != seg) begin
        done = 1'b1;
      end else begin
        if (pkt == int'(SEGMENT_CHECK_PACKET) && segn == 0) redo = 1'b1;
        pkt++;
        if (pkt >= pps) begin
          pkt = 0;
          if (redo) redo = 1'b0;
          else if (seg >= spf) done = 1'b1;
          else seg++;
        end
      end
    end
  endtask

  // receiver: random stall bursts, plus a long hold-off on request
  initial begin
    int stall;
    stall = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holds_served != holds_asked) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        holds_served++;
      end else if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        m_axis_tready <= 1'b0;
        stall = $urandom_range(0, 14);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // run limit
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // stimulus and verdict
  initial begin
    int p;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = REG_PAYLOAD_BYTES;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    holds_asked   = 0;
    holds_served  = 0;
    quiet         = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset registers: a byte with no frame is dropped, then a packet start
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hab, 1'b0);
    send_byte(8'hcd, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h5a, 1'b0);
    settle();
    configure(1, 2, 2);
    // discard packet first in the frame aborts it
    send_byte({4'h0, DISCARD_NIBBLE}, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h77, 1'b0);
    // packet number off by one requests a resync
    send_byte(8'h00, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h56, 1'b0);
    send_byte(8'h78, 1'b0);
    send_byte(8'h99, 1'b0);

    for (p = 0; p < PHASES; p++) begin
      settle();
      configure(ph_pl[p], ph_pps[p], ph_spf[p]);
      quiet      = (p == PHASES - 1);
      bytes_left = ph_budget[p];
      if (p == HOLD_PHASE) holds_asked++;
      send_frame(fit(ph_pl[p], MAX_PAYLOAD_BYTES), fit(ph_pps[p], MAX_PACKETS),
                 fit(ph_spf[p], MAX_SEGMENTS), ph_mode[p]);
      while (bytes_left > 0) begin
        if ($urandom_range(0, 5) == 0) begin
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        send_frame(fit(ph_pl[p], MAX_PAYLOAD_BYTES), fit(ph_pps[p], MAX_PACKETS),
                   fit(ph_spf[p], MAX_SEGMENTS), MODE_RANDOM);
      end
    end
    settle();

    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
